// ===== hw/rtl/smx_pkg.sv =====
// ----------------------------------------------------------------------------
// smx_pkg
// Shared types, codes and operation tables for the stack machine executor.
// ----------------------------------------------------------------------------
package smx_pkg;

  localparam int unsigned StackDepthDef  = 256;
  localparam int unsigned ProgramSizeDef = 4096;

  localparam int unsigned ModeW = 5;
  localparam int unsigned DataW = 32;
  localparam int unsigned TgtW  = 12;
  localparam int unsigned NidxW = 13;
  localparam int unsigned ErrW  = 3;

  typedef enum logic [ModeW-1:0] {
    OP_PUSH  = 5'd0,
    OP_ADD   = 5'd1,
    OP_SUB   = 5'd2,
    OP_DIV   = 5'd3,
    OP_MUL   = 5'd4,
    OP_MOD   = 5'd5,
    OP_GT    = 5'd6,
    OP_LT    = 5'd7,
    OP_EQ    = 5'd8,
    OP_NOT   = 5'd9,
    OP_AND   = 5'd10,
    OP_OR    = 5'd11,
    OP_PRINT = 5'd12,
    OP_DUP   = 5'd13,
    OP_DUP2  = 5'd14,
    OP_SWAP  = 5'd15,
    OP_OVER  = 5'd16,
    OP_IF    = 5'd17,
    OP_ELSE  = 5'd18,
    OP_WHILE = 5'd19,
    OP_DO    = 5'd20,
    OP_END   = 5'd21
  } op_e;

  typedef enum logic [ErrW-1:0] {
    ERR_OK      = 3'd0,
    ERR_UNDER   = 3'd1,
    ERR_OVER    = 3'd2,
    ERR_DIV0    = 3'd3,
    ERR_INVALID = 3'd4
  } err_e;

  // operands an operation needs on the stack
  function automatic logic [1:0] smx_need(input logic [ModeW-1:0] mode);
    logic [1:0] r;
    case (mode)
      OP_PUSH, OP_ELSE, OP_WHILE, OP_END:      r = 2'd0;
      OP_NOT, OP_PRINT, OP_DUP, OP_IF, OP_DO:  r = 2'd1;
      default:                                 r = 2'd2;
    endcase
    return r;
  endfunction

  // net change of the stack count
  function automatic logic signed [2:0] smx_grow(input logic [ModeW-1:0] mode);
    logic signed [2:0] r;
    case (mode)
      OP_PUSH, OP_DUP, OP_OVER:                   r = 3'sd1;
      OP_DUP2:                                    r = 3'sd2;
      OP_NOT, OP_SWAP, OP_ELSE, OP_WHILE, OP_END: r = 3'sd0;
      default:                                    r = -3'sd1;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/stack_machine_executor.sv =====
// ----------------------------------------------------------------------------
// stack_machine_executor
// Executes one stack-language instruction per input word.
// ----------------------------------------------------------------------------
// The data stack lives in a synchronous RAM with one read and one write port.
// Each instruction reads the top two entries one after the other, executes,
// and writes back; dup2 and swap write back twice, and div and mod wait for
// the bit-serial divider. One instruction is in flight at a time; a new word
// is taken as soon as the previous result sits in the output register.
// Faulting instructions (underflow, overflow, divide by zero, bad opcode)
// change nothing and report the current index again.
module stack_machine_executor
  import smx_pkg::*;
#(
  parameter int unsigned STACK_DEPTH  = StackDepthDef,
  parameter int unsigned PROGRAM_SIZE = ProgramSizeDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // mode[4:0], literal_value[36:5], jump_target[48:37], target_present[49]
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // next_index[12:0], print_valid[13], print_value[45:14], error_code[48:46]
  output logic [55:0] m_axis_tdata
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned PW = $clog2(PROGRAM_SIZE + 1);
  localparam int unsigned NW = ((PW > TgtW) ? PW : TgtW) + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_RDA, S_RDB, S_CAP, S_EXE, S_DIV, S_WR2, S_DONE
  } state_e;

  state_e           state_q;
  logic [ModeW-1:0] mode_q;
  logic [DataW-1:0] lit_q, a_q, b_q;
  logic [TgtW-1:0]  tgt_q;
  logic             tp_q;
  logic [CW-1:0]    cnt_q, cnt_new_q;
  logic [PW-1:0]    pidx_q;
  logic [NW-1:0]    nidx_q;
  logic [ErrW-1:0]  err_q;
  logic             pv_q;
  logic [DataW-1:0] pval_q;
  logic             m_valid_q;
  logic [55:0]      m_data_q;

  // RAM
  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic [DataW-1:0] wdata, rdata;

  smx_ram #(.Width(DataW), .Depth(STACK_DEPTH)) u_ram (
    .clk_i,
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // divider
  logic             div_start, div_busy, div_done;
  logic [DataW-1:0] div_quo, div_rem, mag_a, mag_b;

  assign mag_a = a_q[DataW-1] ? (~a_q + 1'b1) : a_q;
  assign mag_b = b_q[DataW-1] ? (~b_q + 1'b1) : b_q;

  smx_div u_div (
    .clk_i,
    .rst_ni,
    .start_i    (div_start),
    .dividend_i (mag_b),
    .divisor_i  (mag_a),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quo),
    .rem_o      (div_rem)
  );

  // execute-stage decode
  logic [ErrW-1:0]   err;
  logic              ok, is_div, wr1, is_two;
  logic [CW:0]       cnt_ext;
  logic signed [2:0] grow;
  logic [NW-1:0]     nxt_raw, nxt;
  logic [DataW-1:0]  r, wr1_data;
  logic [AW-1:0]     wr1_addr;
  logic [DataW-1:0]  div_res;

  assign grow    = smx_grow(mode_q);
  assign cnt_ext = {1'b0, cnt_q};

  always_comb begin
    err = ERR_OK;
    if (mode_q > OP_END) begin
      err = ERR_INVALID;
    end else if (cnt_ext < (CW + 1)'(smx_need(mode_q))) begin
      err = ERR_UNDER;
    end else if (grow > 3'sd0 &&
                 cnt_ext + (CW + 1)'(grow) > (CW + 1)'(STACK_DEPTH)) begin
      err = ERR_OVER;
    end else if ((mode_q == OP_DIV || mode_q == OP_MOD) && a_q == '0) begin
      err = ERR_DIV0;
    end
  end

  assign ok     = (err == ERR_OK);
  assign is_div = (mode_q == OP_DIV) || (mode_q == OP_MOD);
  assign is_two = (mode_q == OP_DUP2) || (mode_q == OP_SWAP);

  always_comb begin
    case (mode_q)
      OP_ADD:  r = b_q + a_q;
      OP_SUB:  r = b_q - a_q;
      OP_MUL:  r = b_q * a_q;
      OP_GT:   r = DataW'($signed(b_q) > $signed(a_q));
      OP_LT:   r = DataW'($signed(b_q) < $signed(a_q));
      OP_EQ:   r = DataW'(a_q == b_q);
      OP_AND:  r = DataW'(a_q != '0 && b_q != '0);
      OP_OR:   r = DataW'(a_q != '0 || b_q != '0);
      default: r = '0;
    endcase
  end

  // first write-back: address and data
  always_comb begin
    wr1      = 1'b1;
    wr1_addr = AW'(cnt_q);
    wr1_data = r;
    case (mode_q)
      OP_PUSH: wr1_data = lit_q;
      OP_DUP:  wr1_data = a_q;
      OP_OVER, OP_DUP2: wr1_data = b_q;
      OP_NOT: begin
        wr1_addr = AW'(cnt_q - 1'b1);
        wr1_data = DataW'(a_q == '0);
      end
      OP_SWAP: begin
        wr1_addr = AW'(cnt_q - 2'd2);
        wr1_data = a_q;
      end
      OP_ADD, OP_SUB, OP_MUL, OP_GT, OP_LT, OP_EQ, OP_AND, OP_OR: begin
        wr1_addr = AW'(cnt_q - 2'd2);
      end
      default: wr1 = 1'b0;
    endcase
  end

  always_comb begin
    nxt_raw = NW'(pidx_q) + 1'b1;
    case (mode_q)
      OP_IF, OP_DO: if (a_q == '0) nxt_raw = NW'(tgt_q) + 1'b1;
      OP_ELSE:      nxt_raw = NW'(tgt_q) + 1'b1;
      OP_END:       if (tp_q) nxt_raw = NW'(tgt_q);
      default:      ;
    endcase
    nxt = (nxt_raw > NW'(PROGRAM_SIZE)) ? NW'(PROGRAM_SIZE) : nxt_raw;
  end

  always_comb begin
    if (mode_q == OP_DIV) begin
      div_res = (a_q[DataW-1] ^ b_q[DataW-1]) ? (~div_quo + 1'b1) : div_quo;
    end else begin
      div_res = b_q[DataW-1] ? (~div_rem + 1'b1) : div_rem;
    end
  end

  assign div_start = (state_q == S_EXE) && ok && is_div;

  always_comb begin
    we    = 1'b0;
    waddr = wr1_addr;
    wdata = wr1_data;
    case (state_q)
      S_EXE: we = ok && wr1;
      S_WR2: begin
        we    = 1'b1;
        waddr = (mode_q == OP_DUP2) ? AW'(cnt_q + 1'b1) : AW'(cnt_q - 1'b1);
        wdata = (mode_q == OP_DUP2) ? a_q : b_q;
      end
      S_DIV: begin
        we    = div_done;
        waddr = AW'(cnt_q - 2'd2);
        wdata = div_res;
      end
      default: ;
    endcase
  end

  assign raddr = (state_q == S_RDA) ? AW'(cnt_q - 1'b1) : AW'(cnt_q - 2'd2);

  assign s_axis_tready = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      pidx_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      // in S_DONE the output register is either refilled or left holding
      if (m_valid_q && m_axis_tready && state_q != S_DONE) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            state_q <= S_RDA;
          end
        end
        S_RDA: state_q <= S_RDB;
        S_RDB: state_q <= S_CAP;
        S_CAP: state_q <= S_EXE;
        S_EXE: begin
          if (ok && is_div) begin
            state_q <= S_DIV;
          end else if (ok && is_two) begin
            state_q <= S_WR2;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_q <= S_DONE;
          end
        end
        S_WR2: state_q <= S_DONE;
        S_DONE: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            if (err_q == ERR_OK) begin
              cnt_q  <= cnt_new_q;
              pidx_q <= PW'(nidx_q);
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      mode_q <= s_axis_tdata[4:0];
      lit_q  <= s_axis_tdata[36:5];
      tgt_q  <= s_axis_tdata[48:37];
      tp_q   <= s_axis_tdata[49];
    end
    if (state_q == S_RDB) begin
      a_q <= rdata;
    end
    if (state_q == S_CAP) begin
      b_q <= rdata;
    end
    if (state_q == S_EXE) begin
      err_q     <= err;
      pv_q      <= ok && (mode_q == OP_PRINT);
      pval_q    <= (ok && (mode_q == OP_PRINT)) ? a_q : '0;
      nidx_q    <= ok ? nxt : NW'(pidx_q);
      cnt_new_q <= CW'($signed({2'b00, cnt_q}) + grow);
    end
    if (state_q == S_DONE && (!m_valid_q || m_axis_tready)) begin
      m_data_q <= {7'd0, err_q, pval_q, pv_q, nidx_q[NidxW-1:0]};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_err_no_print: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && err_q != ERR_OK) |-> !pv_q)
    else $error("faulting word marked as print");

  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> state_q == S_DIV)
    else $error("divider busy outside divide state");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE && state_q != S_DONE) |=> $stable(cnt_q))
    else $error("stack count moved mid-instruction");

endmodule

// ===== hw/rtl/smx_ram.sv =====
// ----------------------------------------------------------------------------
// smx_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module smx_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== hw/rtl/smx_div.sv =====
// ----------------------------------------------------------------------------
// smx_div
// Unsigned 32-bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module smx_div
  import smx_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DataW-1:0] dividend_i,
  input  logic [DataW-1:0] divisor_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [DataW-1:0] quot_o,
  output logic [DataW-1:0] rem_o
);

  localparam int unsigned CntW = $clog2(DataW + 1);

  logic             busy_q, done_q;
  logic [CntW-1:0]  cnt_q;
  logic [DataW:0]   rem_q;
  logic [DataW-1:0] quo_q, dsr_q;
  logic [DataW:0]   rem_sh, rem_sub;
  logic             fits;

  assign rem_sh  = {rem_q[DataW-1:0], quo_q[DataW-1]};
  assign rem_sub = rem_sh - {1'b0, dsr_q};
  assign fits    = rem_sh >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DataW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? rem_sub : rem_sh;
      quo_q <= {quo_q[DataW-2:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q[DataW-1:0];

endmodule
